// File: rtl/lfps_pkg.sv
package lfps_pkg;

    localparam int E_W     = 13;  // line position / error
    localparam int GAIN_W  = 16;  // signed Q8.8 gains
    localparam int BASE_W  = 8;   // unsigned base drive
    localparam int SUM_W   = 14;  // integral
    localparam int SLOPE_W = 14;  // derivative
    localparam int DRIVE_W = 9;   // signed wheel drive
    localparam int RAW_W   = 32;  // sum of the three Q8.8 products

    localparam int SUM_LIMIT = 5000;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_SENSOR = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE   = 3'd4;

    typedef struct packed {
        logic                     sensor_attached;
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [BASE_W-1:0]        base_drive;
    } cfg_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] left_drive;
        logic signed [DRIVE_W-1:0] right_drive;
    } drive_t;

endpackage

// File: rtl/lfps_core.sv
module lfps_core #(
    parameter int MAX_CORR  = 255,
    parameter int MAX_DRIVE = 255
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              step,
    input  logic signed [lfps_pkg::E_W-1:0]   error_in,
    input  lfps_pkg::cfg_t                    cfg,
    output lfps_pkg::drive_t                  drive
);
    import lfps_pkg::*;

    localparam int LIM     = MAX_CORR * 256;
    localparam int CORR_W  = $clog2(LIM + 1) + 1;
    localparam int BQ_W    = BASE_W + 8 + 1;
    localparam int DSUM_W  = ((CORR_W > BQ_W) ? CORR_W : BQ_W) + 1;
    localparam int WHOLE_W = DSUM_W - 8;

    localparam logic signed [RAW_W-1:0]   LIM_POS = RAW_W'(LIM);
    localparam logic signed [RAW_W-1:0]   LIM_NEG = -LIM_POS;
    localparam logic signed [SUM_W:0]     SUM_HI  = (SUM_W + 1)'(SUM_LIMIT);
    localparam logic signed [SUM_W:0]     SUM_LO  = -SUM_HI;
    localparam logic signed [WHOLE_W-1:0] DRV_HI  = WHOLE_W'(MAX_DRIVE);
    localparam logic signed [WHOLE_W-1:0] DRV_LO  = -DRV_HI;

    logic signed [SUM_W-1:0]   error_sum_reg,   error_sum_next;
    logic signed [E_W-1:0]     last_error_reg;
    logic signed [SLOPE_W-1:0] error_slope_reg, error_slope_next;

    logic signed [GAIN_W+E_W-1:0]     prod_p;
    logic signed [GAIN_W+SUM_W-1:0]   prod_i;
    logic signed [GAIN_W+SLOPE_W-1:0] prod_d;
    logic signed [RAW_W-1:0]          raw;
    logic                             in_window;
    logic signed [SUM_W:0]            sum_ext;
    logic signed [CORR_W-1:0]         corr;
    logic signed [BQ_W-1:0]           base_q;
    logic signed [DSUM_W-1:0]         left_q,  right_q;
    logic signed [DSUM_W-1:0]         left_a,  right_a;
    logic signed [WHOLE_W-1:0]        left_w,  right_w;

    function automatic logic signed [DRIVE_W-1:0] sat_drive(
        input logic signed [WHOLE_W-1:0] w
    );
        logic signed [WHOLE_W-1:0] s;
        begin
            if (w > DRV_HI) begin
                s = DRV_HI;
            end else if (w < DRV_LO) begin
                s = DRV_LO;
            end else begin
                s = w;
            end
            return s[DRIVE_W-1:0];
        end
    endfunction

    always_comb begin
        prod_p = cfg.gain_p * error_in;
        prod_i = cfg.gain_i * error_sum_reg;
        prod_d = cfg.gain_d * error_slope_reg;
        raw    = RAW_W'(prod_p) + RAW_W'(prod_i) + RAW_W'(prod_d);

        in_window = (raw < LIM_POS) && (raw > LIM_NEG);

        // The integral only moves while the correction is inside its limit.
        sum_ext = (SUM_W + 1)'(error_sum_reg) + (SUM_W + 1)'(error_in);
        if (!in_window) begin
            error_sum_next = error_sum_reg;
        end else if (sum_ext > SUM_HI) begin
            error_sum_next = SUM_HI[SUM_W-1:0];
        end else if (sum_ext < SUM_LO) begin
            error_sum_next = SUM_LO[SUM_W-1:0];
        end else begin
            error_sum_next = sum_ext[SUM_W-1:0];
        end

        error_slope_next = SLOPE_W'(error_in) - SLOPE_W'(last_error_reg);

        if (raw > LIM_POS) begin
            corr = LIM_POS[CORR_W-1:0];
        end else if (raw < LIM_NEG) begin
            corr = LIM_NEG[CORR_W-1:0];
        end else begin
            corr = raw[CORR_W-1:0];
        end

        base_q  = $signed({1'b0, cfg.base_drive, 8'h00});
        left_q  = DSUM_W'(base_q) + DSUM_W'(corr);
        right_q = DSUM_W'(base_q) - DSUM_W'(corr);

        // Bias negative values so the arithmetic shift truncates toward zero.
        left_a  = left_q  + (left_q[DSUM_W-1]  ? DSUM_W'(255) : DSUM_W'(0));
        right_a = right_q + (right_q[DSUM_W-1] ? DSUM_W'(255) : DSUM_W'(0));
        left_w  = left_a[DSUM_W-1:8];
        right_w = right_a[DSUM_W-1:8];

        if (cfg.sensor_attached) begin
            drive.left_drive  = sat_drive(left_w);
            drive.right_drive = sat_drive(right_w);
        end else begin
            drive.left_drive  = '0;
            drive.right_drive = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg   <= '0;
            last_error_reg  <= '0;
            error_slope_reg <= '0;
        end else if (step && cfg.sensor_attached) begin
            error_sum_reg   <= error_sum_next;
            last_error_reg  <= error_in;
            error_slope_reg <= error_slope_next;
        end
    end

endmodule

// File: rtl/line_follow_pid_steering.sv
// Line-following PID steering with conditional anti-windup.
// Each input transaction is registered on acceptance, and its result is then registered in the
// output stage, where it is held until it is taken.
// Throughput: one transaction per cycle while m_tready does not hold the output; the
// integral/derivative loop closes through three parallel multipliers, an adder and the clamps.
// Reset (aresetn, synchronous, active low) clears the configuration registers, the PID state and
// both channel valids.
module line_follow_pid_steering #(
    parameter int MAX_CORR  = 255,
    parameter int MAX_DRIVE = 255
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lfps_pkg::S_TDATA_W-1:0]      s_tdata,   // [12:0] line_position

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lfps_pkg::M_TDATA_W-1:0]      m_tdata,   // [8:0] left_drive, [17:9] right_drive

    input  logic                                cfg_wr_en,
    input  logic [lfps_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [lfps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import lfps_pkg::*;

    cfg_t                  cfg_reg;
    logic                  in_valid_reg;
    logic signed [E_W-1:0] in_error_reg;
    logic                  out_valid_reg;
    drive_t                out_drive_reg;
    drive_t                drive;
    logic                  out_free;
    logic                  advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SENSOR: cfg_reg.sensor_attached <= cfg_wdata[0];
                REG_GAIN_P: cfg_reg.gain_p          <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_I: cfg_reg.gain_i          <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_D: cfg_reg.gain_d          <= cfg_wdata[GAIN_W-1:0];
                REG_BASE:   cfg_reg.base_drive      <= cfg_wdata[BASE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_error_reg <= s_tdata[E_W-1:0];
        end
    end

    lfps_core #(
        .MAX_CORR  (MAX_CORR),
        .MAX_DRIVE (MAX_DRIVE)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .error_in (in_error_reg),
        .cfg      (cfg_reg),
        .drive    (drive)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_drive_reg <= drive;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - 2 * DRIVE_W)'(0),
                       out_drive_reg.right_drive, out_drive_reg.left_drive};

endmodule

// File: tb/line_follow_pid_steering_test.sv
`timescale 1ns / 1ps

module line_follow_pid_steering_test;
    import lfps_pkg::*;

    localparam int MAX_CORR    = 255;
    localparam int MAX_DRIVE   = 255;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 8;
    localparam int PHASE_ITEMS = 225;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // [12:0] line_position
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // [8:0] left_drive, [17:9] right_drive
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Shadow of the register file and of the controller state.
    cfg_t                       regs;
    logic signed [SUM_W-1:0]    error_sum;
    logic signed [E_W-1:0]      last_error;
    logic signed [SLOPE_W-1:0]  error_slope;

    drive_t drive_queue[$];
    int     fail_count;
    int     accepted_count;
    int     checked_count;
    int     held_count;
    int     setting_count;
    int     walk_pos;
    bit     steady;  // when set, neither side idles

    line_follow_pid_steering #(
        .MAX_CORR  (MAX_CORR),
        .MAX_DRIVE (MAX_DRIVE)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Run did not finish within %0d cycles.", CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin : result_check
        drive_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (drive_queue.size() == 0) begin
                $error("unexpected result transaction, m_tdata=%h", m_tdata);
                fail_count++;
            end else begin
                want = drive_queue.pop_front();
                checked_count++;
                if (m_tdata[DRIVE_W-1:0] !== want.left_drive) begin
                    $error("left_drive: expected %0d, actual %0d", want.left_drive,
                           $signed(m_tdata[DRIVE_W-1:0]));
                    fail_count++;
                end
                if (m_tdata[2*DRIVE_W-1:DRIVE_W] !== want.right_drive) begin
                    $error("right_drive: expected %0d, actual %0d", want.right_drive,
                           $signed(m_tdata[2*DRIVE_W-1:DRIVE_W]));
                    fail_count++;
                end
            end
        end
    end

    function automatic logic signed [DRIVE_W-1:0] wheel_cmd(longint q88);
        longint whole;
        whole = q88 / 256;  // signed division truncates toward zero
        if (whole > MAX_DRIVE)
            whole = MAX_DRIVE;
        else if (whole < -MAX_DRIVE)
            whole = -MAX_DRIVE;
        return whole[DRIVE_W-1:0];
    endfunction

    function automatic drive_t steer_predict(logic signed [E_W-1:0] pos);
        longint raw;
        longint lim;
        longint corr;
        longint acc;
        longint base;
        drive_t cmd;
        cmd = '0;
        if (!regs.sensor_attached)
            return cmd;
        raw = longint'(regs.gain_p) * longint'(pos)
            + longint'(regs.gain_i) * longint'(error_sum)
            + longint'(regs.gain_d) * longint'(error_slope);
        lim = MAX_CORR * 256;
        // The integral only moves while the correction is not saturated.
        if (raw < lim && raw > -lim) begin
            acc = longint'(error_sum) + longint'(pos);
            if (acc > SUM_LIMIT)
                acc = SUM_LIMIT;
            else if (acc < -SUM_LIMIT)
                acc = -SUM_LIMIT;
            error_sum = acc[SUM_W-1:0];
        end else begin
            held_count++;
        end
        corr = (raw > lim) ? lim : (raw < -lim) ? -lim : raw;
        acc = longint'(pos) - longint'(last_error);
        error_slope = acc[SLOPE_W-1:0];
        last_error = pos;
        base = longint'(regs.base_drive) * 256;
        cmd.left_drive  = wheel_cmd(base + corr);
        cmd.right_drive = wheel_cmd(base - corr);
        return cmd;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain(bit small_only);
        int pick;
        pick = small_only ? 1 : $urandom_range(3);
        case (pick)
            0:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            1:       return CFG_DATA_W'(int'($urandom_range(1024)) - 512);
            default: return CFG_DATA_W'($urandom_range(65535));
        endcase
    endfunction

    // Mostly a random walk, like a real line drifting under the sensor bar.
    function automatic logic signed [E_W-1:0] next_position();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            walk_pos = walk_pos + int'($urandom_range(64)) - 32;
            if (walk_pos > 4095)
                walk_pos = 4095;
            else if (walk_pos < -4096)
                walk_pos = -4096;
        end else if (pick < 85) begin
            walk_pos = int'($urandom_range(8191)) - 4096;
        end else begin
            case ($urandom_range(3))
                0:       walk_pos = -4096;
                1:       walk_pos = 4095;
                2:       walk_pos = 0;
                default: walk_pos = -1;
            endcase
        end
        return walk_pos[E_W-1:0];
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (addr)
            REG_SENSOR: regs.sensor_attached = data[0];
            REG_GAIN_P: regs.gain_p = data;
            REG_GAIN_I: regs.gain_i = data;
            REG_GAIN_D: regs.gain_d = data;
            REG_BASE:   regs.base_drive = data[BASE_W-1:0];
            default:    ;
        endcase
    endtask

    // Upper bits of the sensor and base writes are random and must be ignored.
    task automatic set_regs(input bit sensor, input logic [CFG_DATA_W-1:0] gp,
                            input logic [CFG_DATA_W-1:0] gi,
                            input logic [CFG_DATA_W-1:0] gd, input logic [BASE_W-1:0] base);
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_BASE, {8'($urandom), base});
        write_reg(REG_SENSOR, {15'($urandom), sensor});
        setting_count++;
    endtask

    task automatic send_item(input logic signed [E_W-1:0] pos);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(S_TDATA_W-E_W){1'b0}}, pos};
        do @(posedge aclk); while (!s_tready);
        drive_queue.push_back(steer_predict(pos));
        accepted_count++;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (drive_queue.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic test_sensor_off();
        send_item(13'sd4095);
        send_item(-13'sd4096);
        wait_idle();
    endtask

    task automatic test_register_map();
        write_reg(REG_BASE, 16'hAB80);
        write_reg(REG_SENSOR, 16'hFFFE);
        send_item(13'sd4095);
        wait_idle();
        // Writes above the last register must not alias onto the gains.
        for (int a = REG_BASE + 1; a < (1 << CFG_ADDR_W); a++)
            write_reg(CFG_ADDR_W'(a), 16'h7FFF);
        write_reg(REG_SENSOR, 16'hFFFF);
        send_item(13'sd1000);
        wait_idle();
    endtask

    task automatic test_saturation();
        set_regs(1'b1, 16'h0100, 16'h0000, 16'h0000, 8'd100);
        send_item(13'sd4095);
        send_item(-13'sd4096);
        send_item(13'sd0);
        send_item(-13'sd1);
        wait_idle();
    endtask

    task automatic test_integral_limits();
        set_regs(1'b1, 16'h0000, 16'h0000, 16'h0000, 8'd0);
        send_item(13'sd4095);
        send_item(13'sd4095);
        send_item(-13'sd4096);
        send_item(-13'sd4096);
        send_item(-13'sd4096);
        wait_idle();
        // The integral sits at its lower limit; 13 keeps the correction just inside.
        set_regs(1'b1, 16'h0000, 16'd13, 16'h0000, 8'd0);
        send_item(13'sd0);
        send_item(-13'sd1);
        wait_idle();
        set_regs(1'b1, 16'h0000, 16'd14, 16'h0000, 8'd0);
        send_item(13'sd7);
        wait_idle();
    endtask

    task automatic test_truncation();
        set_regs(1'b1, 16'h0001, 16'h0000, 16'h0000, 8'd0);
        send_item(-13'sd300);
        send_item(13'sd255);
        send_item(-13'sd255);
        send_item(13'sd511);
        wait_idle();
    endtask

    task automatic test_gain_extremes();
        set_regs(1'b1, 16'h8000, 16'h7FFF, 16'h8000, 8'd255);
        send_item(13'sd4095);
        send_item(-13'sd4096);
        send_item(13'sd1);
        wait_idle();
    endtask

    task automatic test_random_control();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       set_regs(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 8'd255);
                1:       set_regs(1'b1, 16'h8000, 16'h8000, 16'h8000, 8'd0);
                2, 7:    set_regs(1'b1, pick_gain(1'b1), pick_gain(1'b1), pick_gain(1'b1),
                                  8'($urandom));
                5:       set_regs(1'b0, pick_gain(1'b0), pick_gain(1'b0), pick_gain(1'b0),
                                  8'($urandom));
                default: set_regs(1'b1, pick_gain(1'b0), pick_gain(1'b0), pick_gain(1'b0),
                                  8'($urandom));
            endcase
            steady = (ph == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Hold off the sender mid-stream until every result is back.
                if (ph == 6 && n == PHASE_ITEMS / 2)
                    wait_idle();
                send_item(next_position());
            end
            wait_idle();
        end
        steady = 1'b0;
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        regs        = '0;
        error_sum   = '0;
        last_error  = '0;
        error_slope = '0;
        walk_pos    = 0;
        steady      = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_sensor_off();
        test_register_map();
        test_saturation();
        test_integral_limits();
        test_truncation();
        test_gain_extremes();
        test_random_control();

        $display("Sent %0d transactions, checked %0d results over %0d register settings.",
                 accepted_count, checked_count, setting_count);
        $display("The integral was held by anti-windup on %0d of them.", held_count);
        if (fail_count == 0 && drive_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results missing.", fail_count, drive_queue.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/lfps_pkg.sv
rtl/lfps_core.sv
rtl/line_follow_pid_steering.sv
tb/line_follow_pid_steering_test.sv
